// ===== hdl/mqrf_pkg.sv =====
// ----------------------------------------------------------------------------
// mqrf_pkg
// Shared types, sizes and codes of the multi-queue ring fifo core.
// ----------------------------------------------------------------------------
package mqrf_pkg;

  // number of queues and words per queue (depth must be a power of two)
  localparam int NUM_QUEUES  = 8;
  localparam int QUEUE_DEPTH = 256;

  localparam int QID_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int ADDR_W = QID_W + PTR_W;
  localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;

  // fixed field widths
  localparam int MODE_W   = 3;
  localparam int QSEL_W   = 3;
  localparam int WORD_W   = 32;
  localparam int OFFSET_W = 8;
  localparam int FILL_W   = 9;
  localparam int ERR_W    = 2;
  localparam int PADDR_W  = 3;

  // compare width that holds a pointer difference, an offset and the depth
  localparam int CMP_W = ((PTR_W > OFFSET_W) ? PTR_W : OFFSET_W) + 1;

  localparam logic [FILL_W-1:0] DEPTH_FILL  = FILL_W'(QUEUE_DEPTH % (1 << FILL_W));
  localparam logic [WORD_W-1:0] HEAD_LOCKED = 32'hffff_ffff;

  localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_EMPTY     = 2'd2;
  localparam logic [ERR_W-1:0] ERR_MOD_EMPTY = 2'd3;

  // command queue between front and back
  localparam int CQ_DEPTH = 2;
  localparam int CQ_AW    = 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_ENQ       = 3'd0,
    MODE_DEQ       = 3'd1,
    MODE_PEEK      = 3'd2,
    MODE_COUNT     = 3'd3,
    MODE_MODIFY    = 3'd4,
    MODE_RESET_Q   = 3'd5,
    MODE_RESET_ALL = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    BK_NONE,
    BK_WRITE,
    BK_READ,
    BK_MODIFY
  } back_op_t;

  typedef enum logic {
    BS_IDLE,
    BS_READ
  } back_state_t;

  typedef struct packed {
    back_op_t            op;
    logic [ADDR_W-1:0]   addr;
    logic [WORD_W-1:0]   data;
    logic [WORD_W-1:0]   mask;
    logic [FILL_W-1:0]   fill;
    logic [ERR_W-1:0]    err;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_push_t;

endpackage

// ===== hdl/mqrf_front.sv =====
// ----------------------------------------------------------------------------
// mqrf_front
// Holds the queue pointers, classifies each word and queues a store command.
// ----------------------------------------------------------------------------
module mqrf_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [mqrf_pkg::MODE_W-1:0]   mode,
  input  logic [mqrf_pkg::QSEL_W-1:0]   queue_id,
  input  logic                          is_zombie,
  input  logic [mqrf_pkg::WORD_W-1:0]   data_in,
  input  logic [mqrf_pkg::WORD_W-1:0]   bit_mask,
  input  logic [mqrf_pkg::OFFSET_W-1:0] peek_offset,
  input  logic                          zombies_ctl,
  output mqrf_pkg::cmd_push_t           push
);
  import mqrf_pkg::*;

  logic [PTR_W-1:0] rd_ptr_r [NUM_QUEUES];
  logic [PTR_W-1:0] wr_ptr_r [NUM_QUEUES];
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_cur;
  logic [PTR_W-1:0] wr_cur;
  logic [PTR_W-1:0] wr_inc;
  logic [PTR_W-1:0] held_cur;
  logic [PTR_W-1:0] held_nxt;
  logic [CMP_W-1:0] peek_sum;
  logic [QID_W-1:0] qi;
  logic             q_ok;
  logic             zombie;
  logic             clear_all;
  cmd_t             cmd;

  assign qi     = QID_W'(queue_id);
  assign q_ok   = (int'(queue_id) < NUM_QUEUES);
  assign zombie = is_zombie & ~zombies_ctl;
  assign rd_cur = rd_ptr_r[qi];
  assign wr_cur = wr_ptr_r[qi];
  assign wr_inc = wr_cur + PTR_W'(1);
  assign held_cur = wr_cur - rd_cur;
  assign peek_sum = CMP_W'(rd_cur) + CMP_W'(peek_offset);

  always_comb begin
    rd_ptr_nxt = rd_cur;
    wr_ptr_nxt = wr_cur;
    clear_all  = 1'b0;
    cmd.op     = BK_NONE;
    cmd.addr   = {qi, rd_cur};
    cmd.data   = data_in;
    cmd.mask   = bit_mask;
    cmd.err    = ERR_OK;
    case (mode_t'(mode))
      MODE_ENQ: begin
        if (!zombie) begin
          cmd.op     = BK_WRITE;
          cmd.addr   = {qi, wr_cur};
          wr_ptr_nxt = wr_inc;
          if (wr_inc == rd_cur) begin
            cmd.err = ERR_OVERFLOW;
          end
        end
      end
      MODE_DEQ: begin
        if (!zombie) begin
          if (rd_cur == wr_cur) begin
            cmd.err = ERR_EMPTY;
          end else begin
            cmd.op     = BK_READ;
            rd_ptr_nxt = rd_cur + PTR_W'(1);
          end
        end
      end
      MODE_PEEK: begin
        if (!zombie) begin
          if (CMP_W'(peek_offset) >= CMP_W'(held_cur)) begin
            cmd.err = ERR_EMPTY;
          end else begin
            cmd.op   = BK_READ;
            cmd.addr = {qi, peek_sum[PTR_W-1:0]};
          end
        end
      end
      MODE_COUNT: begin
      end
      MODE_MODIFY: begin
        // zombie modify sees a full queue and always touches the head slot
        if (!zombie && held_cur == '0) begin
          cmd.err = ERR_MOD_EMPTY;
        end else begin
          cmd.op = BK_MODIFY;
        end
      end
      MODE_RESET_Q: begin
        rd_ptr_nxt = '0;
        wr_ptr_nxt = '0;
      end
      MODE_RESET_ALL: begin
        rd_ptr_nxt = '0;
        wr_ptr_nxt = '0;
        clear_all  = 1'b1;
      end
      default: begin
      end
    endcase
    held_nxt = wr_ptr_nxt - rd_ptr_nxt;
    cmd.fill = zombie ? DEPTH_FILL : FILL_W'(CMP_W'(held_nxt));
    // queue outside the populated range: no state change, all-zero result
    if (!q_ok) begin
      cmd.op   = BK_NONE;
      cmd.err  = ERR_OK;
      cmd.fill = '0;
    end
  end

  assign push.valid = accept;
  assign push.cmd   = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && clear_all)) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        rd_ptr_r[i] <= '0;
        wr_ptr_r[i] <= '0;
      end
    end else if (accept && q_ok) begin
      rd_ptr_r[qi] <= rd_ptr_nxt;
      wr_ptr_r[qi] <= wr_ptr_nxt;
    end
  end

endmodule

// ===== hdl/mqrf_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// mqrf_cmd_queue
// Short command queue that decouples the front from the word store.
// ----------------------------------------------------------------------------
module mqrf_cmd_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mqrf_pkg::cmd_push_t  push,
  input  logic                 pop,
  output logic                 full,
  output logic                 nonempty,
  output mqrf_pkg::cmd_t       head
);
  import mqrf_pkg::*;

  cmd_t             entry_r [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_idx_r;
  logic [CQ_AW-1:0] rd_idx_r;
  logic [CQ_AW:0]   count_r;
  logic [CQ_AW:0]   count_nxt;

  assign full     = (count_r == (CQ_AW+1)'(CQ_DEPTH));
  assign nonempty = (count_r != '0);
  assign head     = entry_r[rd_idx_r];

  always_comb begin
    count_nxt = count_r;
    case ({push.valid, pop})
      2'b10:   count_nxt = count_r + (CQ_AW+1)'(1);
      2'b01:   count_nxt = count_r - (CQ_AW+1)'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      count_r  <= '0;
    end else begin
      if (push.valid) begin
        wr_idx_r <= wr_idx_r + CQ_AW'(1);
      end
      if (pop) begin
        rd_idx_r <= rd_idx_r + CQ_AW'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entry_r[wr_idx_r] <= push.cmd;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (CQ_AW+1)'(CQ_DEPTH))
    else $error("command queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("pop from empty command queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> !full)
    else $error("push into full command queue");

endmodule

// ===== hdl/mqrf_back.sv =====
// ----------------------------------------------------------------------------
// mqrf_back
// Word store and its sequencer; carries out commands and holds the result.
// ----------------------------------------------------------------------------
module mqrf_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cq_nonempty,
  input  mqrf_pkg::cmd_t                 cq_head,
  output logic                           cq_pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mqrf_pkg::WORD_W-1:0]    out_data_out,
  output logic [mqrf_pkg::FILL_W-1:0]    out_fill_count,
  output logic [mqrf_pkg::ERR_W-1:0]     out_error_code
);
  import mqrf_pkg::*;

  logic [WORD_W-1:0] mem [0:MEM_DEPTH-1];
  logic [WORD_W-1:0] rd_data_r;

  back_state_t       state_r;
  back_state_t       state_nxt;
  cmd_t              cur_r;

  logic              out_free;
  logic              start;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [WORD_W-1:0] mem_wdata;
  logic              out_load;
  logic [WORD_W-1:0] out_data_nxt;
  logic [FILL_W-1:0] out_fill_nxt;
  logic [ERR_W-1:0]  out_err_nxt;

  logic              out_valid_r;
  logic [WORD_W-1:0] out_data_r;
  logic [FILL_W-1:0] out_fill_r;
  logic [ERR_W-1:0]  out_err_r;

  assign out_free = !out_valid_r || out_ready;
  assign start    = (state_r == BS_IDLE) && cq_nonempty && out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BS_IDLE: begin
        if (start && (cq_head.op == BK_READ || cq_head.op == BK_MODIFY)) begin
          state_nxt = BS_READ;
        end
      end
      BS_READ: begin
        if (out_free) begin
          state_nxt = BS_IDLE;
        end
      end
      default: state_nxt = BS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cq_pop       = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_addr     = cq_head.addr;
    mem_wdata    = cq_head.data;
    out_load     = 1'b0;
    out_data_nxt = '0;
    out_fill_nxt = cq_head.fill;
    out_err_nxt  = cq_head.err;
    case (state_r)
      BS_IDLE: begin
        if (start) begin
          cq_pop = 1'b1;
          case (cq_head.op)
            BK_WRITE: begin
              mem_we   = 1'b1;
              out_load = 1'b1;
            end
            BK_READ, BK_MODIFY: begin
              mem_re = 1'b1;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      BS_READ: begin
        mem_addr     = cur_r.addr;
        mem_wdata    = (rd_data_r & ~cur_r.mask) | (cur_r.data & cur_r.mask);
        out_fill_nxt = cur_r.fill;
        out_err_nxt  = cur_r.err;
        if (out_free) begin
          out_load = 1'b1;
          if (cur_r.op == BK_READ) begin
            out_data_nxt = rd_data_r;
          end else if (rd_data_r != HEAD_LOCKED) begin
            mem_we = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cq_pop) begin
      cur_r <= cq_head;
    end
    if (out_load) begin
      out_data_r <= out_data_nxt;
      out_fill_r <= out_fill_nxt;
      out_err_r  <= out_err_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data_out   = out_data_r;
  assign out_fill_count = out_fill_r;
  assign out_error_code = out_err_r;

  a_read_op: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BS_READ |-> (cur_r.op == BK_READ || cur_r.op == BK_MODIFY))
    else $error("read state holds a command that needs no read");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cq_pop || state_r == BS_READ))
    else $error("result appeared without a command behind it");

endmodule

// ===== hdl/multi_queue_ring_fifo_core.sv =====
// ----------------------------------------------------------------------------
// multi_queue_ring_fifo_core
// Eight circular word queues sharing one word store, driven by command words.
// ----------------------------------------------------------------------------
// usage:
//   in_* is a valid/ready channel; each word names an operation (enqueue,
//   dequeue, peek, count, masked head modify, reset queue, reset all) and a
//   queue. out_* returns exactly one result word per input word, in order.
//   the apb port holds one register, zombies_controllable, at address 0;
//   write it only while no word is in flight.
// result path:
//   a result is registered after its word has passed the command queue;
//   dequeue, peek and modify read the word store into a register first.
//   enqueue, count and resets run at one word per cycle while out_ready is
//   high; dequeue, peek and modify pass through the read state of the back
//   end, which waits for the registered store read and, for modify, does the
//   write-back on the single store port, and starts no new command meanwhile.
// reset:
//   rst_n clears all queue pointers, the command queue and the result
//   register; the word store itself is not cleared and needs no sweep.
// stalls:
//   when out_ready is low the result is held; the front keeps taking words
//   into a two-entry command queue and drops in_ready once that queue fills.
// ----------------------------------------------------------------------------
module multi_queue_ring_fifo_core (
  input  logic                           clk,
  input  logic                           rst_n,
  // input word channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [mqrf_pkg::MODE_W-1:0]    in_mode,
  input  logic [mqrf_pkg::QSEL_W-1:0]    in_queue_id,
  input  logic                           in_is_zombie,
  input  logic [mqrf_pkg::WORD_W-1:0]    in_data_in,
  input  logic [mqrf_pkg::WORD_W-1:0]    in_bit_mask,
  input  logic [mqrf_pkg::OFFSET_W-1:0]  in_peek_offset,
  // result word channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mqrf_pkg::WORD_W-1:0]    out_data_out,
  output logic [mqrf_pkg::FILL_W-1:0]    out_fill_count,
  output logic [mqrf_pkg::ERR_W-1:0]     out_error_code,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mqrf_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import mqrf_pkg::*;

  logic      zombies_ctl_r;
  logic      cfg_hit;
  logic      in_accept;
  logic      cq_full;
  logic      cq_nonempty;
  logic      cq_pop;
  cmd_push_t cq_push;
  cmd_t      cq_head;

  // register 0 sits at byte address 0; higher words of the space read zero
  assign cfg_hit = (paddr[PADDR_W-1:2] == '0);
  assign pready  = 1'b1;
  assign prdata  = cfg_hit ? {31'b0, zombies_ctl_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zombies_ctl_r <= 1'b0;
    end else if (psel && penable && pwrite && cfg_hit) begin
      zombies_ctl_r <= pwdata[0];
    end
  end

  // front takes a word whenever the command queue has room
  assign in_ready  = ~cq_full;
  assign in_accept = in_valid & ~cq_full;

  mqrf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .mode        (in_mode),
    .queue_id    (in_queue_id),
    .is_zombie   (in_is_zombie),
    .data_in     (in_data_in),
    .bit_mask    (in_bit_mask),
    .peek_offset (in_peek_offset),
    .zombies_ctl (zombies_ctl_r),
    .push        (cq_push)
  );

  mqrf_cmd_queue u_cmd_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cq_push),
    .pop      (cq_pop),
    .full     (cq_full),
    .nonempty (cq_nonempty),
    .head     (cq_head)
  );

  mqrf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cq_nonempty    (cq_nonempty),
    .cq_head        (cq_head),
    .cq_pop         (cq_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data_out   (out_data_out),
    .out_fill_count (out_fill_count),
    .out_error_code (out_error_code)
  );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-queue ring fifo core: a short table of
// directed words, then random command streams, each result checked against
// a typed result or an in-bench model of the eight queues, random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import mqrf_pkg::*;

  // mode 7 has no enum member but is still a legal input word
  localparam logic [MODE_W-1:0]  MODE_UNUSED     = 3'd7;
  localparam logic [PADDR_W-1:0] REG_ZOMBIE_CTRL = 3'd0;

  // run limits: generous over the slowest legal run
  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned HOLD_AT     = 1100;  // results seen before the long hold-off
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_WAIT  = 10;    // cycles after the last result

  // one command word as the sender presents it
  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [QSEL_W-1:0]   queue_id;
    logic                is_zombie;
    logic [WORD_W-1:0]   data_in;
    logic [WORD_W-1:0]   bit_mask;
    logic [OFFSET_W-1:0] peek_offset;
  } cmd_word_t;

  // one result word
  typedef struct packed {
    logic [WORD_W-1:0] data_out;
    logic [FILL_W-1:0] fill_count;
    logic [ERR_W-1:0]  error_code;
  } result_t;

  // directed row: the word plus an optional hand-written result
  typedef struct {
    cmd_word_t word;
    bit        typed;
    result_t   want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  logic                 in_valid;
  logic                 in_ready;
  logic [MODE_W-1:0]    in_mode;
  logic [QSEL_W-1:0]    in_queue_id;
  logic                 in_is_zombie;
  logic [WORD_W-1:0]    in_data_in;
  logic [WORD_W-1:0]    in_bit_mask;
  logic [OFFSET_W-1:0]  in_peek_offset;

  logic                 out_valid;
  logic                 out_ready;
  logic [WORD_W-1:0]    out_data_out;
  logic [FILL_W-1:0]    out_fill_count;
  logic [ERR_W-1:0]     out_error_code;

  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  multi_queue_ring_fifo_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_queue_id    (in_queue_id),
    .in_is_zombie   (in_is_zombie),
    .in_data_in     (in_data_in),
    .in_bit_mask    (in_bit_mask),
    .in_peek_offset (in_peek_offset),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data_out   (out_data_out),
    .out_fill_count (out_fill_count),
    .out_error_code (out_error_code),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // --------------------------------------------------------------------------
  // bench model of the queues
  // --------------------------------------------------------------------------
  logic [WORD_W-1:0] ring_mem     [MEM_DEPTH];
  bit                slot_written [MEM_DEPTH];  // guards reads of never-written slots
  logic [PTR_W-1:0]  rd_ptr       [NUM_QUEUES];
  logic [PTR_W-1:0]  wr_ptr       [NUM_QUEUES];
  logic              zombie_ctrl;

  result_t   ring_results[$];  // results still owed by the core, oldest first
  dir_row_t  dir_rows[$];

  int unsigned cycle_count;
  int unsigned results_seen;
  int unsigned fail_count;
  bit          steady_flow;    // no idling on either side while set
  bit          hold_done;
  result_t     want_now;

  function automatic logic [PTR_W-1:0] words_held(input logic [QSEL_W-1:0] q);
    return wr_ptr[q] - rd_ptr[q];
  endfunction

  function automatic void clear_rings();
    for (int i = 0; i < NUM_QUEUES; i++) begin
      rd_ptr[i] = '0;
      wr_ptr[i] = '0;
    end
  endfunction

  // apply one accepted word to the model and return the result it must give
  function automatic result_t ring_step(input cmd_word_t w);
    result_t           r;
    logic              zmb;
    logic [QSEL_W-1:0] q;
    logic [ADDR_W-1:0] s;
    logic [PTR_W-1:0]  held;
    r    = '0;
    q    = w.queue_id;
    zmb  = w.is_zombie && !zombie_ctrl;
    held = words_held(q);
    case (w.mode)
      MODE_ENQ: begin
        if (!zmb) begin
          s = {q, wr_ptr[q]};
          ring_mem[s]     = w.data_in;
          slot_written[s] = 1'b1;
          wr_ptr[q]       = wr_ptr[q] + 1'b1;
          // write pointer caught the read pointer: wrapped to empty
          if (wr_ptr[q] == rd_ptr[q]) r.error_code = ERR_OVERFLOW;
        end
      end
      MODE_DEQ: begin
        if (!zmb) begin
          if (held == '0) begin
            r.error_code = ERR_EMPTY;
          end else begin
            r.data_out = ring_mem[{q, rd_ptr[q]}];
            rd_ptr[q]  = rd_ptr[q] + 1'b1;
          end
        end
      end
      MODE_PEEK: begin
        if (!zmb) begin
          if (w.peek_offset >= held) r.error_code = ERR_EMPTY;
          else r.data_out = ring_mem[{q, PTR_W'(rd_ptr[q] + w.peek_offset)}];
        end
      end
      MODE_COUNT: ;
      MODE_MODIFY: begin
        // a zombie word sees a full queue, so it modifies even when empty
        if (!zmb && held == '0) begin
          r.error_code = ERR_MOD_EMPTY;
        end else begin
          s = {q, rd_ptr[q]};
          if (ring_mem[s] != HEAD_LOCKED)
            ring_mem[s] = (ring_mem[s] & ~w.bit_mask) | (w.data_in & w.bit_mask);
        end
      end
      MODE_RESET_Q: begin
        rd_ptr[q] = '0;
        wr_ptr[q] = '0;
      end
      MODE_RESET_ALL: clear_rings();
      default: ;
    endcase
    r.fill_count = zmb ? DEPTH_FILL : FILL_W'(words_held(q));
    return r;
  endfunction

  // random word, shaped to keep queues populated and peeks mostly in range
  function automatic cmd_word_t make_word();
    cmd_word_t        w;
    int unsigned      pick;
    logic [PTR_W-1:0] held;
    w.queue_id = QSEL_W'($urandom_range(0, NUM_QUEUES - 1));
    held = words_held(w.queue_id);
    pick = $urandom_range(0, 99);
    if      (pick < 32) w.mode = MODE_ENQ;
    else if (pick < 52) w.mode = MODE_DEQ;
    else if (pick < 67) w.mode = MODE_PEEK;
    else if (pick < 74) w.mode = MODE_COUNT;
    else if (pick < 89) w.mode = MODE_MODIFY;
    else if (pick < 92) w.mode = MODE_RESET_Q;
    else if (pick < 93) w.mode = MODE_RESET_ALL;
    else                w.mode = MODE_UNUSED;
    w.is_zombie = ($urandom_range(0, 99) < 15);
    // locked heads come from enqueuing all ones
    w.data_in = ($urandom_range(0, 9) == 0) ? HEAD_LOCKED : WORD_W'($urandom);
    pick = $urandom_range(0, 9);
    if      (pick == 0) w.bit_mask = '1;
    else if (pick == 1) w.bit_mask = '0;
    else                w.bit_mask = WORD_W'($urandom);
    if (held != '0 && $urandom_range(0, 3) != 0)
      w.peek_offset = OFFSET_W'($urandom_range(0, held - 1));
    else
      w.peek_offset = OFFSET_W'($urandom_range(0, 255));
    // a zombie modify reads the head slot even when empty; keep it off
    // slots that were never written
    if (w.mode == MODE_MODIFY && w.is_zombie && !zombie_ctrl &&
        !slot_written[{w.queue_id, rd_ptr[w.queue_id]}])
      w.is_zombie = 1'b0;
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // clock and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL multi_queue_ring_fifo_core");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // result side: random ready, one long hold-off, field checks
  // --------------------------------------------------------------------------
  task automatic flag_field(input string what, input logic [31:0] want_v,
                            input logic [31:0] got_v);
    if (want_v !== got_v) begin
      fail_count++;
      $display("%0t mismatch %s: expected %h, got %h", $time, what, want_v, got_v);
    end
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= HOLD_AT) begin
        // hold off long enough for the command queue to fill and stall the input
        hold_done = 1'b1;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ready = steady_flow || ($urandom_range(0, 99) >= 20);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (ring_results.size() == 0) begin
        fail_count++;
        $display("%0t unexpected result word: expected none, got %h %h %h", $time,
                 out_data_out, out_fill_count, out_error_code);
      end else begin
        want_now = ring_results.pop_front();
        flag_field("data_out",   want_now.data_out,   out_data_out);
        flag_field("fill_count", 32'(want_now.fill_count), 32'(out_fill_count));
        flag_field("error_code", 32'(want_now.error_code), 32'(out_error_code));
      end
    end
  end

  // --------------------------------------------------------------------------
  // input side and configuration
  // --------------------------------------------------------------------------
  // called and returning at a falling edge; valid stays up into the next word
  task automatic push_word(input cmd_word_t w, input bit typed, input result_t want);
    result_t r;
    while (!steady_flow && $urandom_range(0, 99) < 20) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_mode        = w.mode;
    in_queue_id    = w.queue_id;
    in_is_zombie   = w.is_zombie;
    in_data_in     = w.data_in;
    in_bit_mask    = w.bit_mask;
    in_peek_offset = w.peek_offset;
    in_valid       = 1'b1;
    do @(posedge clk); while (!in_ready);
    r = ring_step(w);
    ring_results.push_back(typed ? want : r);
    @(negedge clk);
  endtask

  // drop valid and let every word in flight come back before touching config
  task automatic settle();
    in_valid = 1'b0;
    while (ring_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // write the zombie control register, then read it back
  task automatic set_zombie_ctrl(input logic v);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = REG_ZOMBIE_CTRL;
    pwdata  = {31'd0, v};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    zombie_ctrl = v;
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    flag_field("zombies_controllable", {31'd0, v}, {31'd0, prdata[0]});
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic add_row(input logic [MODE_W-1:0] mode, input logic [QSEL_W-1:0] q,
                         input logic zmb, input logic [WORD_W-1:0] data,
                         input logic [WORD_W-1:0] mask, input logic [OFFSET_W-1:0] off,
                         input bit typed, input logic [WORD_W-1:0] dout,
                         input logic [FILL_W-1:0] fill, input logic [ERR_W-1:0] err);
    dir_row_t row;
    row.word  = '{mode, q, zmb, data, mask, off};
    row.typed = typed;
    row.want  = '{dout, fill, err};
    dir_rows.push_back(row);
  endtask

  task automatic run_random(input int unsigned count, input bit flood,
                            input int unsigned steady_items);
    cmd_word_t   w;
    int unsigned n;
    if (flood) begin
      // fill one queue to or past its depth so the write pointer wraps
      w.queue_id    = QSEL_W'($urandom_range(0, NUM_QUEUES - 1));
      w.mode        = MODE_ENQ;
      w.is_zombie   = 1'b0;
      w.bit_mask    = '0;
      w.peek_offset = '0;
      n = QUEUE_DEPTH - int'(words_held(w.queue_id)) + $urandom_range(0, 3);
      for (int unsigned i = 0; i < n; i++) begin
        w.data_in = WORD_W'($urandom);
        push_word(w, 1'b0, '0);
      end
    end
    for (int unsigned i = 0; i < count; i++) begin
      steady_flow = (i < steady_items);
      push_word(make_word(), 1'b0, '0);
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_mode        = MODE_ENQ;
    in_queue_id    = '0;
    in_is_zombie   = 1'b0;
    in_data_in     = '0;
    in_bit_mask    = '0;
    in_peek_offset = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = REG_ZOMBIE_CTRL;
    pwdata         = '0;
    steady_flow    = 1'b0;
    hold_done      = 1'b0;
    cycle_count    = 0;
    results_seen   = 0;
    fail_count     = 0;
    zombie_ctrl    = 1'b0;
    clear_rings();
    for (int i = 0; i < MEM_DEPTH; i++) slot_written[i] = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    set_zombie_ctrl(1'b0);

    // directed words: empty queue errors, locked head, zombie answers,
    // unused mode, single and global resets
    add_row(MODE_COUNT,     3'd0, 1'b0, 32'h0,         32'h0,         8'd0,   1'b1,
            32'h0, 9'd0, ERR_OK);
    add_row(MODE_DEQ,       3'd0, 1'b0, 32'h0,         32'h0,         8'd0,   1'b1,
            32'h0, 9'd0, ERR_EMPTY);
    add_row(MODE_PEEK,      3'd0, 1'b0, 32'h0,         32'h0,         8'd0,   1'b1,
            32'h0, 9'd0, ERR_EMPTY);
    add_row(MODE_MODIFY,    3'd0, 1'b0, 32'h1234,      32'hffff_ffff, 8'd0,   1'b1,
            32'h0, 9'd0, ERR_MOD_EMPTY);
    add_row(MODE_ENQ,       3'd0, 1'b0, 32'hffff_ffff, 32'h0,         8'd0,   1'b1,
            32'h0, 9'd1, ERR_OK);
    add_row(MODE_ENQ,       3'd0, 1'b0, 32'h0,         32'h0,         8'd0,   1'b1,
            32'h0, 9'd2, ERR_OK);
    // head is all ones: the modify must leave it alone
    add_row(MODE_MODIFY,    3'd0, 1'b0, 32'h0,         32'hffff_ffff, 8'd0,   1'b1,
            32'h0, 9'd2, ERR_OK);
    add_row(MODE_PEEK,      3'd0, 1'b0, 32'h0,         32'h0,         8'd0,   1'b1,
            32'hffff_ffff, 9'd2, ERR_OK);
    add_row(MODE_PEEK,      3'd0, 1'b0, 32'h0,         32'h0,         8'd1,   1'b1,
            32'h0, 9'd2, ERR_OK);
    add_row(MODE_PEEK,      3'd0, 1'b0, 32'h0,         32'h0,         8'd255, 1'b1,
            32'h0, 9'd2, ERR_EMPTY);
    add_row(MODE_DEQ,       3'd0, 1'b0, 32'h0,         32'h0,         8'd0,   1'b1,
            32'hffff_ffff, 9'd1, ERR_OK);
    add_row(MODE_ENQ,       3'd7, 1'b0, 32'ha5a5_5a5a, 32'h0,         8'd0,   1'b1,
            32'h0, 9'd1, ERR_OK);
    add_row(MODE_MODIFY,    3'd7, 1'b0, 32'h1234_5678, 32'hffff_0000, 8'd0,   1'b0,
            32'h0, 9'd0, ERR_OK);
    add_row(MODE_DEQ,       3'd7, 1'b0, 32'h0,         32'h0,         8'd0,   1'b0,
            32'h0, 9'd0, ERR_OK);
    // zombie words with zombie control off: fixed answers
    add_row(MODE_ENQ,       3'd1, 1'b1, 32'h5555_aaaa, 32'h0,         8'd0,   1'b1,
            32'h0, DEPTH_FILL, ERR_OK);
    add_row(MODE_COUNT,     3'd1, 1'b0, 32'h0,         32'h0,         8'd0,   1'b1,
            32'h0, 9'd0, ERR_OK);
    add_row(MODE_DEQ,       3'd0, 1'b1, 32'h0,         32'h0,         8'd0,   1'b1,
            32'h0, DEPTH_FILL, ERR_OK);
    add_row(MODE_PEEK,      3'd0, 1'b1, 32'h0,         32'h0,         8'd0,   1'b1,
            32'h0, DEPTH_FILL, ERR_OK);
    add_row(MODE_MODIFY,    3'd0, 1'b1, 32'hdead_beef, 32'hffff_ffff, 8'd0,   1'b1,
            32'h0, DEPTH_FILL, ERR_OK);
    add_row(MODE_DEQ,       3'd0, 1'b0, 32'h0,         32'h0,         8'd0,   1'b0,
            32'h0, 9'd0, ERR_OK);
    add_row(MODE_ENQ,       3'd5, 1'b0, 32'h0f0f_0f0f, 32'h0,         8'd0,   1'b1,
            32'h0, 9'd1, ERR_OK);
    // unused mode with data, mask and offset at their top values
    add_row(MODE_UNUSED,    3'd5, 1'b0, 32'hffff_ffff, 32'hffff_ffff, 8'd255, 1'b1,
            32'h0, 9'd1, ERR_OK);
    add_row(MODE_RESET_Q,   3'd5, 1'b1, 32'h0,         32'h0,         8'd0,   1'b1,
            32'h0, DEPTH_FILL, ERR_OK);
    add_row(MODE_ENQ,       3'd2, 1'b0, 32'h8000_0001, 32'h0,         8'd0,   1'b0,
            32'h0, 9'd0, ERR_OK);
    add_row(MODE_RESET_ALL, 3'd6, 1'b0, 32'h0,         32'h0,         8'd0,   1'b1,
            32'h0, 9'd0, ERR_OK);
    add_row(MODE_COUNT,     3'd2, 1'b0, 32'h0,         32'h0,         8'd0,   1'b1,
            32'h0, 9'd0, ERR_OK);
    foreach (dir_rows[i]) push_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);

    // random streams: control off with an overflow flood, control on with
    // a stretch of no idling, then off again
    settle();
    run_random(350, 1'b1, 0);
    settle();
    set_zombie_ctrl(1'b1);
    run_random(450, 1'b0, 250);
    settle();
    set_zombie_ctrl(1'b0);
    run_random(450, 1'b0, 0);

    in_valid = 1'b0;
    while (ring_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && ring_results.size() == 0)
      $display("PASS multi_queue_ring_fifo_core");
    else
      $display("FAIL multi_queue_ring_fifo_core");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/mqrf_pkg.sv
hdl/mqrf_front.sv
hdl/mqrf_cmd_queue.sv
hdl/mqrf_back.sv
hdl/multi_queue_ring_fifo_core.sv
dv/tb_top.sv
